### rtl/core/tcq_pkg.sv
`default_nettype none

package tcq_pkg;

  // Arrival stamp width; stamps compare modulo 2**STAMP_W.
  localparam int STAMP_W = 16;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int ID_WIDTH_DEF    = 16;

  typedef enum logic [1:0] {
    REQ_ENQ = 2'd0,
    REQ_ANY = 2'd1,
    REQ_DOG = 2'd2,
    REQ_CAT = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_DELIVERED = 2'd2,
    ST_NONE      = 2'd3
  } status_t;

  typedef enum logic {
    KIND_CAT = 1'b0,
    KIND_DOG = 1'b1
  } kind_t;

  // Per-chain command; push and pop never both set.
  typedef struct packed {
    logic push;
    logic pop;
  } chain_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } chain_sts_t;

endpackage

`default_nettype wire

### rtl/core/tcq_cell.sv
`default_nettype none

// One queue slot. Pop shifts the right neighbor in; push lands in the
// first empty slot (own valid low, left neighbor valid).
module tcq_cell
  import tcq_pkg::*;
#(
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire chain_ctl_t          ctl,
  input  wire logic                left_valid,
  input  wire logic                right_valid,
  input  wire logic [ID_WIDTH-1:0] right_id,
  input  wire logic [STAMP_W-1:0]  right_stamp,
  input  wire logic [ID_WIDTH-1:0] new_id,
  input  wire logic [STAMP_W-1:0]  new_stamp,
  output logic                     valid,
  output logic [ID_WIDTH-1:0]      id,
  output logic [STAMP_W-1:0]       stamp
);

  logic load_new;

  assign load_new = ctl.push && !valid && left_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.pop) begin
      valid <= right_valid;
    end else if (load_new) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      id    <= right_id;
      stamp <= right_stamp;
    end else if (load_new) begin
      id    <= new_id;
      stamp <= new_stamp;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tcq_chain.sv
`default_nettype none

// Shift-register FIFO built from a row of slots; slot 0 is the head.
module tcq_chain
  import tcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire chain_ctl_t          ctl,
  input  wire logic [ID_WIDTH-1:0] new_id,
  input  wire logic [STAMP_W-1:0]  new_stamp,
  output chain_sts_t               sts,
  output logic [ID_WIDTH-1:0]      head_id,
  output logic [STAMP_W-1:0]       head_stamp
);

  logic                valid_q [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] id_q    [QUEUE_DEPTH];
  logic [STAMP_W-1:0]  stamp_q [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    logic                lv;
    logic                rv;
    logic [ID_WIDTH-1:0] rid;
    logic [STAMP_W-1:0]  rstamp;

    if (i == 0) begin : g_first
      assign lv = 1'b1;
    end else begin : g_mid
      assign lv = valid_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rv     = 1'b0;
      assign rid    = '0;
      assign rstamp = '0;
    end else begin : g_inner
      assign rv     = valid_q[i+1];
      assign rid    = id_q[i+1];
      assign rstamp = stamp_q[i+1];
    end

    tcq_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_slot (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .left_valid (lv),
      .right_valid(rv),
      .right_id   (rid),
      .right_stamp(rstamp),
      .new_id     (new_id),
      .new_stamp  (new_stamp),
      .valid      (valid_q[i]),
      .id         (id_q[i]),
      .stamp      (stamp_q[i])
    );
  end

  assign sts.empty  = !valid_q[0];
  assign sts.full   = valid_q[QUEUE_DEPTH-1];
  assign head_id    = id_q[0];
  assign head_stamp = stamp_q[0];

endmodule

`default_nettype wire

### rtl/core/two_class_oldest_first_queue.sv
`default_nettype none

// Channel   Direction  Handshake             Beat fields
// request   in         req_valid/req_stall   req_type, item_id, item_kind
// response  out        rsp_valid/rsp_stall   status, out_id, out_kind
//
// One request per cycle while req_stall is low; each accepted request yields one
// response beat in the next cycle. Both queues are rows of slots whose heads sit
// in flops, so take-any stamp compare and push/pop shift run in the accepting cycle.
// The request side stalls only while the response register is full and stalled.
// Synchronous reset empties both queues, zeroes the arrival stamp and drops
// any pending response; no clearing pass is needed.
module two_class_oldest_first_queue
  import tcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // request channel
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic [1:0]          req_type,
  input  wire logic [ID_WIDTH-1:0] item_id,
  input  wire logic                item_kind,
  // response channel
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output logic [1:0]               status,
  output logic [ID_WIDTH-1:0]      out_id,
  output logic                     out_kind
);

  logic accept;

  // Next stamp to hand out; advances only on a successful enqueue.
  logic [STAMP_W-1:0] arrival;

  chain_ctl_t          cat_ctl, dog_ctl;
  chain_sts_t          cat_sts, dog_sts;
  logic [ID_WIDTH-1:0] cat_id, dog_id;
  logic [STAMP_W-1:0]  cat_stamp, dog_stamp;

  // Decoded request, before gating with accept.
  logic                push_cat, push_dog, take_cat, take_dog;
  logic [STAMP_W-1:0]  stamp_diff;
  logic                dog_older;
  status_t             rsp_status_next;
  logic [ID_WIDTH-1:0] rsp_id_next;
  kind_t               rsp_kind_next;

  status_t             rsp_status;
  logic [ID_WIDTH-1:0] rsp_id;
  kind_t               rsp_kind;

  // Output register frees up when its beat is taken this cycle.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // Stamps compare modulo 2**STAMP_W: the dog is older when cat - dog is
  // nonzero and positive. Equal stamps favor the cat.
  assign stamp_diff = cat_stamp - dog_stamp;
  assign dog_older  = (stamp_diff != '0) && !stamp_diff[STAMP_W-1];

  always_comb begin
    push_cat = 1'b0;
    push_dog = 1'b0;
    take_cat = 1'b0;
    take_dog = 1'b0;
    unique case (req_t'(req_type))
      REQ_ENQ: begin
        if (kind_t'(item_kind) == KIND_DOG) begin
          push_dog = !dog_sts.full;
        end else begin
          push_cat = !cat_sts.full;
        end
      end
      REQ_ANY: begin
        if (!cat_sts.empty && (dog_sts.empty || !dog_older)) begin
          take_cat = 1'b1;
        end else begin
          take_dog = !dog_sts.empty;
        end
      end
      REQ_DOG: take_dog = !dog_sts.empty;
      REQ_CAT: take_cat = !cat_sts.empty;
      default: ;
    endcase
  end

  // Response beat; id and kind stay zero unless something is delivered.
  always_comb begin
    rsp_id_next   = '0;
    rsp_kind_next = KIND_CAT;
    if (req_t'(req_type) == REQ_ENQ) begin
      rsp_status_next = (push_cat || push_dog) ? ST_ENQUEUED : ST_FULL;
    end else if (take_cat) begin
      rsp_status_next = ST_DELIVERED;
      rsp_id_next     = cat_id;
    end else if (take_dog) begin
      rsp_status_next = ST_DELIVERED;
      rsp_id_next     = dog_id;
      rsp_kind_next   = KIND_DOG;
    end else begin
      rsp_status_next = ST_NONE;
    end
  end

  assign cat_ctl.push = accept && push_cat;
  assign cat_ctl.pop  = accept && take_cat;
  assign dog_ctl.push = accept && push_dog;
  assign dog_ctl.pop  = accept && take_dog;

  tcq_chain #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_cat_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (cat_ctl),
    .new_id    (item_id),
    .new_stamp (arrival),
    .sts       (cat_sts),
    .head_id   (cat_id),
    .head_stamp(cat_stamp)
  );

  tcq_chain #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_dog_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (dog_ctl),
    .new_id    (item_id),
    .new_stamp (arrival),
    .sts       (dog_sts),
    .head_id   (dog_id),
    .head_stamp(dog_stamp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival <= '0;
    end else if (cat_ctl.push || dog_ctl.push) begin
      arrival <= arrival + STAMP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= rsp_status_next;
      rsp_id     <= rsp_id_next;
      rsp_kind   <= rsp_kind_next;
    end
  end

  assign status   = rsp_status;
  assign out_id   = rsp_id;
  assign out_kind = rsp_kind;

  // Every accepted request leaves a response beat behind.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted request produced no response beat");

  // Only a delivery carries an id or a kind.
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != ST_DELIVERED) |-> (out_id == '0 && out_kind == 1'b0))
    else $error("non-delivery beat carries payload");

  // A pop never hits an empty queue and a push never hits a full one.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (cat_ctl.pop |-> !cat_sts.empty) and (dog_ctl.pop |-> !dog_sts.empty))
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cat_ctl.push |-> !cat_sts.full) and (dog_ctl.push |-> !dog_sts.full))
    else $error("push into full queue");

  // Stamp never moves without a successful enqueue.
  a_stamp_step: assert property (@(posedge clk) disable iff (rst)
    !(cat_ctl.push || dog_ctl.push) |=> arrival == $past(arrival))
    else $error("arrival stamp moved without an enqueue");

endmodule

`default_nettype wire
